FILE: src/sorted_table_floor_search_defines.svh
// Assertion helpers, clocked on i_clk and held off while i_rst_n is low.
`ifndef SORTED_TABLE_FLOOR_SEARCH_DEFINES_SVH
`define SORTED_TABLE_FLOOR_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define STFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/stfs_pkg.sv
`default_nettype none

package stfs_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    localparam int IDX_W = 10;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_SEARCH = 3'b100
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture request, start first table read
        logic exec;   // run clear / append / trivial answer
        logic step;   // one search step
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;  // no entries in the table
        logic last;   // search window closes on this step
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: src/stfs_ctrl.sv
`default_nettype none

module stfs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        i_req_type,
    input  wire stfs_pkg::t_dp_stat i_stat,
    output stfs_pkg::t_dp_cmd      o_cmd,
    output logic                   busy,
    output logic                   o_valid
);

    stfs_pkg::t_state r_state, n_state;
    logic r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            stfs_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_req_type == stfs_pkg::REQ_QUERY && !i_stat.empty) begin
                        n_state = stfs_pkg::S_SEARCH;
                    end else begin
                        n_state = stfs_pkg::S_EXEC;
                    end
                end
            end
            stfs_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_valid    = 1'b1;
                n_state    = stfs_pkg::S_IDLE;
            end
            stfs_pkg::S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    n_valid = 1'b1;
                    n_state = stfs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stfs_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign busy    = (r_state != stfs_pkg::S_IDLE);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

FILE: src/stfs_datapath.sv
`default_nettype none

module stfs_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire stfs_pkg::t_dp_cmd          i_cmd,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic signed [31:0]         i_date_value,
    output stfs_pkg::t_dp_stat              o_stat,
    output logic                            o_found,
    output logic [stfs_pkg::IDX_W-1:0]      o_match_index,
    output logic [1:0]                      o_status
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic signed [31:0] mem [TABLE_DEPTH];

    logic [1:0]         r_req;
    logic signed [31:0] r_target;
    logic signed [31:0] r_last;
    logic signed [31:0] r_rdata;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_lo, r_hi, r_mid;
    logic [CW-1:0]      n_lo, n_hi, n_mid;
    logic [CW:0]        sum_n;
    logic               le;
    logic               wr_en;
    logic [CW-1:0]      idx;
    logic [CW+stfs_pkg::IDX_W-1:0] idx_ext;

    logic               r_found;
    logic [stfs_pkg::IDX_W-1:0] r_index;
    logic [1:0]         r_status;

    // window update from the entry read last cycle
    always_comb begin
        le = (r_rdata <= r_target);
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.load) begin
            n_lo = '0;
            n_hi = r_count;
        end else if (i_cmd.step) begin
            if (le) begin
                n_lo = r_mid + CW'(1);
            end else begin
                n_hi = r_mid;
            end
        end
        sum_n = {1'b0, n_lo} + {1'b0, n_hi};
        n_mid = sum_n[CW:1];
    end

    assign idx     = n_lo - CW'(1);
    assign idx_ext = (CW + stfs_pkg::IDX_W)'(idx);

    assign o_stat.empty = (r_count == '0);
    assign o_stat.last  = (n_lo == n_hi);

    assign wr_en = i_cmd.exec && (r_req == stfs_pkg::REQ_APPEND)
                && (r_count < CW'(TABLE_DEPTH))
                && !((r_count != '0) && (r_target < r_last));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= r_target;
        end
        r_rdata <= mem[n_mid[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            if (r_req == stfs_pkg::REQ_CLEAR) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_target <= i_date_value;
        end
        if (wr_en) begin
            r_last <= r_target;
        end
        if (i_cmd.load || i_cmd.step) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
        end
        if (i_cmd.exec) begin
            r_found  <= 1'b0;
            r_index  <= '0;
            r_status <= stfs_pkg::ST_OK;
            case (r_req)
                stfs_pkg::REQ_APPEND: begin
                    if (r_count >= CW'(TABLE_DEPTH)) begin
                        r_status <= stfs_pkg::ST_FULL;
                    end else if (!wr_en) begin
                        r_status <= stfs_pkg::ST_ORDER;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.step && o_stat.last) begin
            r_found  <= (n_lo != '0);
            r_index  <= (n_lo != '0) ? idx_ext[stfs_pkg::IDX_W-1:0] : '0;
            r_status <= stfs_pkg::ST_OK;
        end
    end

    assign o_found       = r_found;
    assign o_match_index = r_index;
    assign o_status      = r_status;

endmodule

`default_nettype wire

FILE: src/sorted_table_floor_search.sv
`default_nettype none
// Channel   Handshake                      Payload
// request   start in, busy out             i_req_type, i_date_value
// result    o_valid strobe, one cycle      o_found, o_match_index, o_status
//
// A request beat is taken when start is high and busy is low.
// Clear, append and unused codes: the beat moves the controller to S_EXEC, which
// sets the registered result strobe. Query: one search step per cycle over the
// table RAM (one read per step), at most floor(log2(entries)) + 1 steps, strobe
// in the cycle after the last. An empty table answers like a clear.
// Synchronous active-low reset empties the table; no clearing pass is run.
// The result strobe cannot be held off; busy drops in the strobe cycle.

`include "sorted_table_floor_search_defines.svh"

module sorted_table_floor_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_date_value,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [9:0]              o_match_index,
    output logic [1:0]              o_status
);

    stfs_pkg::t_dp_cmd  cmd;
    stfs_pkg::t_dp_stat stat;

    stfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy),
        .o_valid    (o_valid)
    );

    stfs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_date_value  (i_date_value),
        .o_stat        (stat),
        .o_found       (o_found),
        .o_match_index (o_match_index),
        .o_status      (o_status)
    );

    `STFS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `STFS_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe longer than one cycle")
    `STFS_ASSERT_NOW(a_found_ok, o_valid && o_found, o_status == stfs_pkg::ST_OK, "found with bad status")
    `STFS_ASSERT_NOW(a_strobe_idle, o_valid, !busy, "result strobe while busy")

endmodule

`default_nettype wire
